>>> src/afs_pkg.sv
// Shared types and constants for the audio frame sequencer.
`default_nettype none

package afs_pkg;

    // Input command codes
    typedef enum logic [0:0] {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_QUARTER_DIVIDER = 1'b0,
        CFG_SAMPLE_PERIOD   = 1'b1
    } t_cfg_reg;

    localparam int unsigned DIV_W   = 16;
    localparam int unsigned COUNT_W = DIV_W + 1;
    localparam int unsigned STEP_W  = 3;

    localparam logic [DIV_W-1:0] QUARTER_DIVIDER_RESET = 16'd7457;
    localparam logic [DIV_W-1:0] SAMPLE_PERIOD_RESET   = 16'd40;

    // Frame counter register bits
    localparam int unsigned MODE_BIT_POS    = 7;
    localparam int unsigned INHIBIT_BIT_POS = 6;

    // Last step before the counter wraps, per mode
    localparam logic [STEP_W-1:0] STEP_LAST_FOUR = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LAST_FIVE = 3'd4;

    // Pulses from the step sequencer for one word
    typedef struct packed {
        logic even_cycle;
        logic envelope_clock;
        logic sweep_clock;
        logic irq_raise;
        logic irq_clear;
    } t_seq_pulse;

    // One result word as held in the output register
    typedef struct packed {
        t_seq_pulse seq;
        logic       sample_strobe;
    } t_result;

endpackage

`default_nettype wire

>>> src/afs_step_seq.sv
// Parity, inhibit latch, quarter divider and 4/5-step sequencer.
`default_nettype none

module afs_step_seq
    import afs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic             i_cmd,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [DIV_W-1:0] i_quarter_divider,
    output t_seq_pulse            o_pulse
);

    logic              r_parity,         n_parity;
    logic [DIV_W-1:0]  r_quarter_count,  n_quarter_count;
    logic [STEP_W-1:0] r_step_index,     n_step_index;
    logic              r_five_step_mode, n_five_step_mode;
    logic              r_irq_disable,    n_irq_disable;
    logic              r_latch_pending,  n_latch_pending;

    logic [COUNT_W-1:0] w_count_inc;
    logic [COUNT_W-1:0] w_div;
    logic               w_even;

    assign w_count_inc = {1'b0, r_quarter_count} + COUNT_W'(1);
    // A zero divider behaves like one
    assign w_div = (i_quarter_divider == '0) ? COUNT_W'(1) : {1'b0, i_quarter_divider};
    // Parity flips on this tick; the tick is even when the new parity is zero
    assign w_even = r_parity;

    always_comb begin
        n_parity         = r_parity;
        n_quarter_count  = r_quarter_count;
        n_step_index     = r_step_index;
        n_five_step_mode = r_five_step_mode;
        n_irq_disable    = r_irq_disable;
        n_latch_pending  = r_latch_pending;
        o_pulse          = '0;

        if (t_cmd'(i_cmd) == CMD_WRITE) begin
            n_five_step_mode = i_data_byte[MODE_BIT_POS];
            n_irq_disable    = i_data_byte[INHIBIT_BIT_POS];
            n_latch_pending  = 1'b1;
        end else begin
            n_parity           = ~r_parity;
            o_pulse.even_cycle = w_even;

            if (r_latch_pending && w_even) begin
                n_latch_pending   = 1'b0;
                o_pulse.irq_clear = r_irq_disable;
            end

            if (w_count_inc >= w_div) begin
                n_quarter_count = '0;
                if (r_five_step_mode) begin
                    o_pulse.sweep_clock    = (r_step_index == 3'd0) || (r_step_index == 3'd2);
                    o_pulse.envelope_clock = (r_step_index < STEP_LAST_FIVE);
                    n_step_index = (r_step_index >= STEP_LAST_FIVE) ? '0
                                                                    : r_step_index + 3'd1;
                end else begin
                    o_pulse.envelope_clock = 1'b1;
                    o_pulse.irq_raise      = (r_step_index == STEP_LAST_FOUR) && !r_irq_disable;
                    o_pulse.sweep_clock    = (r_step_index == 3'd1) ||
                                             (r_step_index == STEP_LAST_FOUR);
                    n_step_index = (r_step_index >= STEP_LAST_FOUR) ? '0
                                                                    : r_step_index + 3'd1;
                end
            end else begin
                n_quarter_count = w_count_inc[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity         <= 1'b0;
            r_quarter_count  <= '0;
            r_step_index     <= '0;
            r_five_step_mode <= 1'b0;
            r_irq_disable    <= 1'b0;
            r_latch_pending  <= 1'b0;
        end else if (i_advance) begin
            r_parity         <= n_parity;
            r_quarter_count  <= n_quarter_count;
            r_step_index     <= n_step_index;
            r_five_step_mode <= n_five_step_mode;
            r_irq_disable    <= n_irq_disable;
            r_latch_pending  <= n_latch_pending;
        end
    end

endmodule

`default_nettype wire

>>> src/afs_sample_timer.sv
// Sample strobe timer with alternating period and period plus one.
`default_nettype none

module afs_sample_timer
    import afs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tick,
    input  wire logic [DIV_W-1:0] i_sample_period,
    output logic                  o_strobe
);

    logic [COUNT_W-1:0] r_sample_countdown, n_sample_countdown;
    logic               r_interval_toggle,  n_interval_toggle;

    always_comb begin
        o_strobe           = 1'b0;
        n_interval_toggle  = r_interval_toggle;
        n_sample_countdown = r_sample_countdown;
        if (r_sample_countdown <= COUNT_W'(1)) begin
            o_strobe           = 1'b1;
            n_interval_toggle  = ~r_interval_toggle;
            // Reload with the toggled bit: the longer interval comes first
            n_sample_countdown = {1'b0, i_sample_period} + COUNT_W'(n_interval_toggle);
        end else begin
            n_sample_countdown = r_sample_countdown - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_countdown <= {1'b0, SAMPLE_PERIOD_RESET};
            r_interval_toggle  <= 1'b0;
        end else if (i_tick) begin
            r_sample_countdown <= n_sample_countdown;
            r_interval_toggle  <= n_interval_toggle;
        end
    end

endmodule

`default_nettype wire

>>> src/audio_frame_sequencer.sv
// Top level of the audio frame sequencer: channels, config registers, word stages.
//
//   channel  dir  handshake                 payload
//   in       in   i_in_valid / o_in_ready   i_cmd, i_data_byte
//   out      out  o_out_valid / i_out_ready o_even_cycle, o_envelope_clock, o_sweep_clock,
//                                           o_irq_raise, o_irq_clear, o_sample_strobe
//   cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word in, one word out. A word is held in the input register, passes the
// sequencer and sample timer logic, and lands in the output register; one word
// per cycle sustained while i_out_ready stays high.
// The input register takes a new word while a finished result waits at the output;
// only when both stages are full does o_in_ready drop.
// Reset is synchronous, active low; no clearing pass, config registers come up
// at 7457 and 40, the cfg port is always ready.
`default_nettype none

module audio_frame_sequencer
    import afs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_cmd,
    input  wire logic [7:0]       i_data_byte,

    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_even_cycle,
    output logic                  o_envelope_clock,
    output logic                  o_sweep_clock,
    output logic                  o_irq_raise,
    output logic                  o_irq_clear,
    output logic                  o_sample_strobe,

    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_index,
    input  wire logic [DIV_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [DIV_W-1:0] r_quarter_divider;
    logic [DIV_W-1:0] r_sample_period;

    // Input stage
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_data;

    // Output stage
    logic    r_out_valid;
    t_result r_result;
    t_result w_result;

    logic       w_move;
    logic       w_tick;
    t_seq_pulse w_pulse;
    logic       w_strobe;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter_divider <= QUARTER_DIVIDER_RESET;
            r_sample_period   <= SAMPLE_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_QUARTER_DIVIDER: r_quarter_divider <= i_cfg_data;
                CFG_SAMPLE_PERIOD:   r_sample_period   <= i_cfg_data;
                default:             r_quarter_divider <= r_quarter_divider;
            endcase
        end
    end

    // Advance the held word when the output register is free or draining
    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;
    assign w_tick     = w_move && (t_cmd'(r_in_cmd) == CMD_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd  <= i_cmd;
            r_in_data <= i_data_byte;
        end
    end

    afs_step_seq u_step_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (w_move),
        .i_cmd             (r_in_cmd),
        .i_data_byte       (r_in_data),
        .i_quarter_divider (r_quarter_divider),
        .o_pulse           (w_pulse)
    );

    afs_sample_timer u_sample_timer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick          (w_tick),
        .i_sample_period (r_sample_period),
        .o_strobe        (w_strobe)
    );

    // A register write gives an all-zero word: drop the strobe unless ticking
    assign w_result.seq           = w_pulse;
    assign w_result.sample_strobe = w_strobe && (t_cmd'(r_in_cmd) == CMD_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_even_cycle     = r_result.seq.even_cycle;
    assign o_envelope_clock = r_result.seq.envelope_clock;
    assign o_sweep_clock    = r_result.seq.sweep_clock;
    assign o_irq_raise      = r_result.seq.irq_raise;
    assign o_irq_clear      = r_result.seq.irq_clear;
    assign o_sample_strobe  = r_result.sample_strobe;

    // A frame IRQ only comes with a four-step envelope and sweep pulse
    a_irq_with_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_irq_raise |-> o_envelope_clock && o_sweep_clock)
        else $error("irq_raise without envelope and sweep clocks");

    // Every sweep step also clocks the envelopes
    a_sweep_with_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sweep_clock |-> o_envelope_clock)
        else $error("sweep_clock without envelope_clock");

    // The inhibit latch fires only on even ticks, and never with a frame IRQ
    a_clear_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_irq_clear |-> o_even_cycle && !o_irq_raise)
        else $error("irq_clear on odd tick or together with irq_raise");

    // A word leaving the input stage is held in the output register next cycle
    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("moved word lost before the output register");

endmodule

`default_nettype wire
